FILE: src/pmct_pkg.sv
// shared types and constants for the ps/2 mouse packet cursor tracker
package pmct_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIM_BITS   = COORD_BITS + 1;
    localparam int BTN_BITS   = 3;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [DIM_BITS-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [DIM_BITS-1:0] RESET_HEIGHT = 13'd480;

    // first byte bit positions
    localparam int SYNC_BIT = 3;
    localparam int XOVF_BIT = 6;
    localparam int YOVF_BIT = 7;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_ACK  = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

    typedef struct packed {
        logic                mode;
        logic [7:0]          rx_byte;
        logic [BTN_BITS-1:0] ack_mask;
    } item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] cursor_x;
        logic [COORD_BITS-1:0] cursor_y;
        logic [BTN_BITS-1:0]   button_levels;
        logic [BTN_BITS-1:0]   clicks_taken;
        logic [BTN_BITS-1:0]   clicks_pending;
        logic                  packet_applied;
        logic                  packet_dropped;
    } result_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ACK   = 2'd1,
        OP_APPLY = 2'd2,
        OP_DROP  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [BTN_BITS-1:0] mask;
        logic [BTN_BITS-1:0] btn;
        logic [7:0]          dx;
        logic [7:0]          dy;
    } cmd_t;

endpackage

FILE: src/pmct_front.sv
// front end: packet assembly and classification of incoming words
module pmct_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  pmct_pkg::item_t  item,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output pmct_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_THIRD  = 3'b100
    } pos_t;

    pos_t       pos_reg;
    pos_t       pos_next;
    logic [7:0] pkt0_reg;
    logic [7:0] pkt0_next;
    logic [7:0] pkt1_reg;
    logic [7:0] pkt1_next;
    logic       accept;

    assign item_ready = cmd_ready;
    assign cmd_valid  = item_valid;
    assign accept     = item_valid && cmd_ready;

    always_comb
    begin
        pos_next  = pos_reg;
        pkt0_next = pkt0_reg;
        pkt1_next = pkt1_reg;
        cmd.op    = pmct_pkg::OP_NONE;
        cmd.mask  = item.ack_mask;
        cmd.btn   = pkt0_reg[pmct_pkg::BTN_BITS-1:0];
        cmd.dx    = pkt1_reg;
        // negation wraps in eight bits, so -128 stays -128
        cmd.dy    = ~item.rx_byte + 8'd1;
        if (item.mode == pmct_pkg::MODE_ACK)
        begin
            cmd.op = pmct_pkg::OP_ACK;
        end
        else
        begin
            case (pos_reg)
                POS_SECOND:
                begin
                    pkt1_next = item.rx_byte;
                    pos_next  = POS_THIRD;
                end
                POS_THIRD:
                begin
                    pos_next = POS_FIRST;
                    if (pkt0_reg[pmct_pkg::XOVF_BIT] || pkt0_reg[pmct_pkg::YOVF_BIT])
                    begin
                        cmd.op = pmct_pkg::OP_DROP;
                    end
                    else
                    begin
                        cmd.op = pmct_pkg::OP_APPLY;
                    end
                end
                default:
                begin
                    // waiting for sync: drop bytes without the sync bit
                    pos_next = POS_FIRST;
                    if (item.rx_byte[pmct_pkg::SYNC_BIT])
                    begin
                        pkt0_next = item.rx_byte;
                        pos_next  = POS_SECOND;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FIRST;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pkt0_reg <= pkt0_next;
            pkt1_reg <= pkt1_next;
        end
    end

endmodule

FILE: src/pmct_queue.sv
// two-entry command queue between front and back end
module pmct_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pmct_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output pmct_pkg::cmd_t  out_cmd
);

    pmct_pkg::cmd_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: src/pmct_back.sv
// back end: cursor, buttons, click tracking, screen registers and result register
module pmct_back
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    output logic                                   cmd_ready,
    input  pmct_pkg::cmd_t                         cmd,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output pmct_pkg::result_t                      result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pmct_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [pmct_pkg::DIM_BITS-1:0]          cfg_data
);

    localparam int CB = pmct_pkg::COORD_BITS;
    localparam int DB = pmct_pkg::DIM_BITS;
    localparam int SB = pmct_pkg::COORD_BITS + 2;
    localparam int BB = pmct_pkg::BTN_BITS;
    localparam logic [DB-1:0] DIM_ONE = {{CB{1'b0}}, 1'b1};
    localparam logic [DB-1:0] DIM_MAX = {1'b1, {CB{1'b0}}};

    function automatic logic [DB-1:0] eff_dim(input logic [DB-1:0] v);
        logic [DB-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_ONE;
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    function automatic logic [CB-1:0] move_axis(input logic [CB-1:0] p,
                                                 input logic [7:0] d,
                                                 input logic [DB-1:0] dim);
        logic [SB-1:0] sum;
        logic [DB-1:0] last;
        logic [CB-1:0] r;
        sum  = {2'b00, p} + {{(SB-8){d[7]}}, d};
        last = dim - DIM_ONE;
        if (sum[SB-1])
        begin
            r = '0;
        end
        else if (sum[DB-1:0] >= dim)
        begin
            r = last[CB-1:0];
        end
        else
        begin
            r = sum[CB-1:0];
        end
        return r;
    endfunction

    logic [DB-1:0]     dim_w_reg;
    logic [DB-1:0]     dim_w_next;
    logic [DB-1:0]     dim_h_reg;
    logic [DB-1:0]     dim_h_next;
    logic [CB-1:0]     pos_x_reg;
    logic [CB-1:0]     pos_x_next;
    logic [CB-1:0]     pos_y_reg;
    logic [CB-1:0]     pos_y_next;
    logic [BB-1:0]     held_reg;
    logic [BB-1:0]     held_next;
    logic [BB-1:0]     pending_reg;
    logic [BB-1:0]     pending_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    pmct_pkg::result_t result_reg;
    pmct_pkg::result_t result_next;
    logic              take;
    logic              cfg_wr;

    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid;
    assign cmd_ready    = !out_valid_reg || result_ready;
    assign take         = cmd_valid && cmd_ready;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        dim_w_next     = dim_w_reg;
        dim_h_next     = dim_h_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        held_next      = held_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        if (cfg_wr && (cfg_index == pmct_pkg::REG_SCREEN_WIDTH
                       || cfg_index == pmct_pkg::REG_SCREEN_HEIGHT))
        begin
            if (cfg_index == pmct_pkg::REG_SCREEN_WIDTH)
            begin
                dim_w_next = eff_dim(cfg_data);
            end
            else
            begin
                dim_h_next = eff_dim(cfg_data);
            end
            // recentre both axes and release buttons
            pos_x_next = dim_w_next[CB:1];
            pos_y_next = dim_h_next[CB:1];
            held_next  = '0;
        end
        else if (take)
        begin
            result_next.clicks_taken   = '0;
            result_next.packet_applied = 1'b0;
            result_next.packet_dropped = 1'b0;
            case (cmd.op)
                pmct_pkg::OP_ACK:
                begin
                    result_next.clicks_taken = pending_reg & cmd.mask;
                    pending_next             = pending_reg & ~cmd.mask;
                end
                pmct_pkg::OP_APPLY:
                begin
                    pos_x_next   = move_axis(pos_x_reg, cmd.dx, dim_w_reg);
                    pos_y_next   = move_axis(pos_y_reg, cmd.dy, dim_h_reg);
                    pending_next = cmd.btn & ~held_reg;
                    held_next    = cmd.btn;
                    result_next.packet_applied = 1'b1;
                end
                pmct_pkg::OP_DROP:
                begin
                    result_next.packet_dropped = 1'b1;
                end
                default:
                begin
                end
            endcase
            result_next.cursor_x       = pos_x_next;
            result_next.cursor_y       = pos_y_next;
            result_next.button_levels  = held_next;
            result_next.clicks_pending = pending_next;
        end

        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_w_reg     <= pmct_pkg::RESET_WIDTH;
            dim_h_reg     <= pmct_pkg::RESET_HEIGHT;
            pos_x_reg     <= pmct_pkg::RESET_WIDTH[CB:1];
            pos_y_reg     <= pmct_pkg::RESET_HEIGHT[CB:1];
            held_reg      <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dim_w_reg     <= dim_w_next;
            dim_h_reg     <= dim_h_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            held_reg      <= held_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

FILE: src/ps2_mouse_packet_cursor_tracker_unit.sv
// top level of the ps/2 mouse packet cursor tracker
// Takes one word per clock while item_ready is high: received mouse bytes (mode 0) or
// click acknowledges (mode 1), and returns exactly one result word per item word, in order.
// The front end syncs on a first byte with bit 3 set, gathers three-byte packets and
// classifies them; a two-entry command queue decouples it from the back end, which adds
// the signed moves to the cursor, clamps to the screen and tracks buttons and pending
// clicks. A result word passes through the queue entry and the result register after
// its item word is accepted, and with the result side taking every word the block
// sustains one word per cycle. Screen width and height (registers 0 and 1) are clamped
// to 1..4096; writing either recentres the cursor and releases the buttons.
module ps2_mouse_packet_cursor_tracker_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  pmct_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output pmct_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pmct_pkg::DIM_BITS-1:0]       cfg_data
);

    logic           fq_valid;
    logic           fq_ready;
    pmct_pkg::cmd_t fq_cmd;
    logic           qb_valid;
    logic           qb_ready;
    pmct_pkg::cmd_t qb_cmd;

    pmct_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (fq_valid),
        .cmd_ready  (fq_ready),
        .cmd        (fq_cmd)
    );

    pmct_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    pmct_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (qb_valid),
        .cmd_ready    (qb_ready),
        .cmd          (qb_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

FILE: test/tb_ps2_mouse_packet_cursor_tracker_unit.sv
// self-checking testbench for the ps/2 mouse packet cursor tracker
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor_tracker_unit;

    localparam int COORD_LIMIT = 1 << pmct_pkg::COORD_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS = 250;
    localparam int MAX_REPORTS = 40;
    // index that decodes to no register
    localparam logic [pmct_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    pmct_pkg::item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    pmct_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pmct_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [pmct_pkg::DIM_BITS-1:0] cfg_data = '0;

    ps2_mouse_packet_cursor_tracker_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // expected tracker state
    logic [pmct_pkg::DIM_BITS-1:0] screen_w;
    logic [pmct_pkg::DIM_BITS-1:0] screen_h;
    logic [1:0] byte_pos;
    logic [7:0] head_byte;
    logic [7:0] move_byte;
    int pos_x;
    int pos_y;
    logic [pmct_pkg::BTN_BITS-1:0] held_buttons;
    logic [pmct_pkg::BTN_BITS-1:0] pending_clicks;

    pmct_pkg::item_t mouse_words_to_send[$];
    pmct_pkg::result_t cursor_reports_due[$];

    int item_gap = 0;
    int ready_hold = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;
    int idle_cycles = 0;

    int mismatches = 0;
    int bytes_seen = 0;
    int acks_seen = 0;
    int packets_applied = 0;
    int packets_dropped = 0;
    int reg_writes = 0;

    function automatic int usable_dim(input logic [pmct_pkg::DIM_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > COORD_LIMIT)
            return COORD_LIMIT;
        return int'(v);
    endfunction

    function automatic int clamp_axis(input int p, input int dim);
        if (p < 0)
            return 0;
        if (p >= dim)
            return dim - 1;
        return p;
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 10));
    endfunction

    task automatic recentre_cursor();
        pos_x = usable_dim(screen_w) / 2;
        pos_y = usable_dim(screen_h) / 2;
        held_buttons = '0;
    endtask

    task automatic apply_reg(input logic [pmct_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [pmct_pkg::DIM_BITS-1:0] value);
        if (index == pmct_pkg::REG_SCREEN_WIDTH)
        begin
            screen_w = value;
            recentre_cursor();
        end
        else if (index == pmct_pkg::REG_SCREEN_HEIGHT)
        begin
            screen_h = value;
            recentre_cursor();
        end
    endtask

    task automatic track_mouse_item(input pmct_pkg::item_t mouse_word);
        pmct_pkg::result_t due;
        int dx;
        int dy;
        due = '0;
        if (mouse_word.mode == pmct_pkg::MODE_ACK)
        begin
            due.clicks_taken = pending_clicks & mouse_word.ack_mask;
            pending_clicks = pending_clicks & ~mouse_word.ack_mask;
            acks_seen++;
        end
        else
        begin
            bytes_seen++;
            case (byte_pos)
                2'd1:
                begin
                    move_byte = mouse_word.rx_byte;
                    byte_pos = 2'd2;
                end
                2'd2:
                begin
                    byte_pos = 2'd0;
                    if (head_byte[pmct_pkg::XOVF_BIT] || head_byte[pmct_pkg::YOVF_BIT])
                    begin
                        due.packet_dropped = 1'b1;
                        packets_dropped++;
                    end
                    else
                    begin
                        dx = int'($signed(move_byte));
                        dy = -int'($signed(mouse_word.rx_byte));
                        // negation wraps in 8 bits
                        if (dy == 128)
                            dy = -128;
                        pos_x = clamp_axis(pos_x + dx, usable_dim(screen_w));
                        pos_y = clamp_axis(pos_y + dy, usable_dim(screen_h));
                        pending_clicks = head_byte[pmct_pkg::BTN_BITS-1:0] & ~held_buttons;
                        held_buttons = head_byte[pmct_pkg::BTN_BITS-1:0];
                        due.packet_applied = 1'b1;
                        packets_applied++;
                    end
                end
                default:
                begin
                    byte_pos = 2'd0;
                    if (mouse_word.rx_byte[pmct_pkg::SYNC_BIT])
                    begin
                        head_byte = mouse_word.rx_byte;
                        byte_pos = 2'd1;
                    end
                end
            endcase
        end
        due.cursor_x = pos_x[pmct_pkg::COORD_BITS-1:0];
        due.cursor_y = pos_y[pmct_pkg::COORD_BITS-1:0];
        due.button_levels = held_buttons;
        due.clicks_pending = pending_clicks;
        cursor_reports_due.push_back(due);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    task automatic check_result(input pmct_pkg::result_t got);
        pmct_pkg::result_t want;
        if (cursor_reports_due.size() == 0)
        begin
            report_mismatch("result word with nothing outstanding", 1, 0);
            return;
        end
        want = cursor_reports_due.pop_front();
        if (got.cursor_x !== want.cursor_x)
            report_mismatch("cursor_x", int'(got.cursor_x), int'(want.cursor_x));
        if (got.cursor_y !== want.cursor_y)
            report_mismatch("cursor_y", int'(got.cursor_y), int'(want.cursor_y));
        if (got.button_levels !== want.button_levels)
            report_mismatch("button_levels", int'(got.button_levels),
                            int'(want.button_levels));
        if (got.clicks_taken !== want.clicks_taken)
            report_mismatch("clicks_taken", int'(got.clicks_taken),
                            int'(want.clicks_taken));
        if (got.clicks_pending !== want.clicks_pending)
            report_mismatch("clicks_pending", int'(got.clicks_pending),
                            int'(want.clicks_pending));
        if (got.packet_applied !== want.packet_applied)
            report_mismatch("packet_applied", int'(got.packet_applied),
                            int'(want.packet_applied));
        if (got.packet_dropped !== want.packet_dropped)
            report_mismatch("packet_dropped", int'(got.packet_dropped),
                            int'(want.packet_dropped));
    endtask

    // item side: one word per handshake, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_gap <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                track_mouse_item(item);
            if (!item_valid || item_ready)
            begin
                if (item_gap > 0)
                begin
                    item_valid <= 1'b0;
                    item_gap <= item_gap - 1;
                end
                else if (mouse_words_to_send.size() > 0)
                begin
                    if ($urandom_range(0, 31) == 0)
                        send_burst = !send_burst;
                    item <= mouse_words_to_send.pop_front();
                    item_valid <= 1'b1;
                    item_gap <= draw_wait(send_burst);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result side: random stall after each accepted word
    always @(posedge clk or negedge rst_n)
    begin : result_side
        int stall;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            ready_hold <= 0;
        end
        else
        begin
            stall = ready_hold;
            if (result_valid && result_ready)
            begin
                check_result(result);
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                stall = draw_wait(recv_burst);
            end
            else if (stall > 0)
                stall = stall - 1;
            ready_hold <= stall;
            result_ready <= (stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no handshake for %0d cycles, %0d words still outstanding",
                     idle_cycles, cursor_reports_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic queue_byte(input logic [7:0] b);
        pmct_pkg::item_t w;
        w.mode = pmct_pkg::MODE_BYTE;
        w.rx_byte = b;
        w.ack_mask = 3'($urandom_range(0, 7));
        mouse_words_to_send.push_back(w);
    endtask

    task automatic queue_ack(input logic [pmct_pkg::BTN_BITS-1:0] mask);
        pmct_pkg::item_t w;
        w.mode = pmct_pkg::MODE_ACK;
        w.rx_byte = 8'($urandom_range(0, 255));
        w.ack_mask = mask;
        mouse_words_to_send.push_back(w);
    endtask

    function automatic logic [7:0] pick_move(input bit drift_up);
        // steady drift pushes the cursor onto the screen edges
        if ($urandom_range(0, 9) < 4)
            return drift_up ? 8'h7F : 8'h80;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_random_traffic(input int n);
        int sent;
        int pick;
        bit drift_x;
        bit drift_y;
        logic [7:0] pkt[3];
        sent = 0;
        drift_x = 1'($urandom_range(0, 1));
        drift_y = 1'($urandom_range(0, 1));
        while (sent < n)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 72)
            begin
                pkt[0] = 8'($urandom_range(0, 255));
                pkt[0][pmct_pkg::SYNC_BIT] = 1'b1;
                if ($urandom_range(0, 9) != 0)
                begin
                    pkt[0][pmct_pkg::XOVF_BIT] = 1'b0;
                    pkt[0][pmct_pkg::YOVF_BIT] = 1'b0;
                end
                pkt[1] = pick_move(drift_x);
                pkt[2] = pick_move(drift_y);
                for (int k = 0; k < 3; k++)
                begin
                    if (k > 0 && $urandom_range(0, 7) == 0)
                    begin
                        queue_ack(3'($urandom_range(0, 7)));
                        sent++;
                    end
                    queue_byte(pkt[k]);
                    sent++;
                end
            end
            else if (pick < 88)
            begin
                queue_ack(3'($urandom_range(0, 7)));
                sent++;
            end
            else
            begin
                // stray byte, may start a bogus packet
                queue_byte(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    task automatic write_reg(input logic [pmct_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [pmct_pkg::DIM_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(index, value);
        reg_writes++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (mouse_words_to_send.size() != 0 || item_valid || cursor_reports_due.size() != 0);
    endtask

    initial
    begin
        screen_w = pmct_pkg::RESET_WIDTH;
        screen_h = pmct_pkg::RESET_HEIGHT;
        byte_pos = 2'd0;
        head_byte = '0;
        move_byte = '0;
        pending_clicks = '0;
        recentre_cursor();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // nothing pending yet, then bytes without the sync bit while hunting
        queue_ack(3'b111);
        queue_byte(8'h00);
        queue_byte(8'hF7);
        // all buttons down, largest right move, dy of -128 stays -128
        queue_byte(8'h0F);
        queue_byte(8'h7F);
        queue_byte(8'h80);
        // acknowledges in the middle of a packet
        queue_byte(8'h09);
        queue_ack(3'b010);
        queue_byte(8'h80);
        queue_ack(3'b101);
        queue_byte(8'h7F);
        // overflow on both axes, x only, y only
        queue_byte(8'hC8);
        queue_byte(8'hFF);
        queue_byte(8'hFF);
        queue_byte(8'h48);
        queue_byte(8'h01);
        queue_byte(8'h01);
        queue_byte(8'h8F);
        queue_byte(8'h00);
        queue_byte(8'h00);
        wait_idle();

        // zero width acts as one pixel, oversized height as the full range
        write_reg(pmct_pkg::REG_SCREEN_WIDTH, '0);
        write_reg(pmct_pkg::REG_SCREEN_HEIGHT, '1);
        @(negedge clk);
        queue_byte(8'h0A);
        queue_byte(8'h7F);
        queue_byte(8'h81);
        queue_byte(8'h08);
        queue_byte(8'h80);
        queue_byte(8'h7F);
        wait_idle();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(pmct_pkg::REG_SCREEN_WIDTH, 13'd4096);
                    write_reg(pmct_pkg::REG_SCREEN_HEIGHT, 13'd1);
                end
                1:
                begin
                    write_reg(pmct_pkg::REG_SCREEN_WIDTH, 13'd1);
                    write_reg(pmct_pkg::REG_SCREEN_HEIGHT, 13'd4096);
                end
                2:
                begin
                    write_reg(pmct_pkg::REG_SCREEN_WIDTH, 13'($urandom_range(1, 4096)));
                    write_reg(pmct_pkg::REG_SCREEN_HEIGHT, 13'($urandom_range(1, 4096)));
                end
                3:
                begin
                    write_reg(pmct_pkg::REG_SCREEN_WIDTH, 13'($urandom_range(2, 48)));
                    write_reg(pmct_pkg::REG_SCREEN_HEIGHT, 13'($urandom_range(2, 48)));
                end
                default:
                begin
                    write_reg(pmct_pkg::REG_SCREEN_WIDTH, 13'($urandom_range(4097, 8191)));
                    write_reg(pmct_pkg::REG_SCREEN_HEIGHT, 13'($urandom_range(1, 300)));
                    // no register behind this index, the cursor must not move
                    write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));
                end
            endcase
            @(negedge clk);
            queue_random_traffic(PHASE_WORDS);
            wait_idle();
        end

        repeat (4) @(posedge clk);
        $display("sent %0d mouse bytes and %0d click acknowledges over %0d register writes",
                 bytes_seen, acks_seen, reg_writes);
        $display("packets moved the cursor %0d times, %0d dropped for overflow",
                 packets_applied, packets_dropped);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
